>>> rtl/core/csc_pkg.sv
`default_nettype none

package csc_pkg;

  localparam int MAX_SUBSAMPLES_DEF = 6;

  // Rounding shifts of the shared multiplier
  localparam logic [5:0] SH_GYRO  = 6'd24;
  localparam logic [5:0] SH_ACCEL = 6'd28;
  localparam logic [5:0] SH_COEF  = 6'd30;
  localparam logic [5:0] SH_CROSS = 6'd32;
  localparam logic [5:0] SH_HALF  = 6'd33;

  localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

  // Coefficients, unsigned Q2.30, round(num/den * 2^30)
  localparam logic [31:0] C2_0 = 32'(((64'd2 << 31) / 64'd3 + 64'd1) >> 1);
  localparam logic [31:0] C3_0 = 32'(((64'd9 << 31) / 64'd20 + 64'd1) >> 1);
  localparam logic [31:0] C3_1 = 32'(((64'd27 << 31) / 64'd20 + 64'd1) >> 1);
  localparam logic [31:0] C4_0 = 32'(((64'd54 << 31) / 64'd105 + 64'd1) >> 1);
  localparam logic [31:0] C4_1 = 32'(((64'd92 << 31) / 64'd105 + 64'd1) >> 1);
  localparam logic [31:0] C4_2 = 32'(((64'd214 << 31) / 64'd105 + 64'd1) >> 1);
  localparam logic [31:0] C5_0 = 32'(((64'd250 << 31) / 64'd504 + 64'd1) >> 1);
  localparam logic [31:0] C5_1 = 32'(((64'd525 << 31) / 64'd504 + 64'd1) >> 1);
  localparam logic [31:0] C5_2 = 32'(((64'd650 << 31) / 64'd504 + 64'd1) >> 1);
  localparam logic [31:0] C5_3 = 32'(((64'd1375 << 31) / 64'd504 + 64'd1) >> 1);
  localparam logic [31:0] C6_0 = 32'(((64'd2315 << 31) / 64'd4620 + 64'd1) >> 1);
  localparam logic [31:0] C6_1 = 32'(((64'd4558 << 31) / 64'd4620 + 64'd1) >> 1);
  localparam logic [31:0] C6_2 = 32'(((64'd7296 << 31) / 64'd4620 + 64'd1) >> 1);
  localparam logic [31:0] C6_3 = 32'(((64'd7834 << 31) / 64'd4620 + 64'd1) >> 1);
  localparam logic [31:0] C6_4 = 32'(((64'd15797 << 31) / 64'd4620 + 64'd1) >> 1);

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         shift;
  } csc_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
  } csc_mul_rsp_t;

  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic [1:0] comp;
    logic       negate;
  } csc_cross_t;

  // Coefficient for group size n and subsample col
  function automatic logic [31:0] csc_coef(input logic [2:0] n, input logic [2:0] col);
    logic [31:0] c;
    c = '0;
    case (n)
      3'd2: c = C2_0;
      3'd3: begin
        case (col)
          3'd0:    c = C3_0;
          default: c = C3_1;
        endcase
      end
      3'd4: begin
        case (col)
          3'd0:    c = C4_0;
          3'd1:    c = C4_1;
          default: c = C4_2;
        endcase
      end
      3'd5: begin
        case (col)
          3'd0:    c = C5_0;
          3'd1:    c = C5_1;
          3'd2:    c = C5_2;
          default: c = C5_3;
        endcase
      end
      default: begin
        case (col)
          3'd0:    c = C6_0;
          3'd1:    c = C6_1;
          3'd2:    c = C6_2;
          3'd3:    c = C6_3;
          default: c = C6_4;
        endcase
      end
    endcase
    return c;
  endfunction

  // Cross product term: comp i gets +a[i+1]b[i+2] - a[i+2]b[i+1]
  function automatic csc_cross_t csc_cross_sel(input logic [2:0] sub);
    csc_cross_t s;
    s = '0;
    case (sub)
      3'd0:    s = '{a_idx: 2'd1, b_idx: 2'd2, comp: 2'd0, negate: 1'b0};
      3'd1:    s = '{a_idx: 2'd2, b_idx: 2'd1, comp: 2'd0, negate: 1'b1};
      3'd2:    s = '{a_idx: 2'd2, b_idx: 2'd0, comp: 2'd1, negate: 1'b0};
      3'd3:    s = '{a_idx: 2'd0, b_idx: 2'd2, comp: 2'd1, negate: 1'b1};
      3'd4:    s = '{a_idx: 2'd0, b_idx: 2'd1, comp: 2'd2, negate: 1'b0};
      default: s = '{a_idx: 2'd1, b_idx: 2'd0, comp: 2'd2, negate: 1'b1};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/csc_mulshift.sv
`default_nettype none

// round(a*b / 2^shift) half away from zero, magnitude capped at 2^63-1.
// One 32x32 multiplier, four partial products, then a rounding step.
module csc_mulshift (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire csc_pkg::csc_mul_req_t req,
  output csc_pkg::csc_mul_rsp_t      rsp
);
  import csc_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_ROUND} ustate_t;

  ustate_t       state;
  logic [63:0]   ua;
  logic [63:0]   ub;
  logic          neg;
  logic [5:0]    shift;
  logic [2:0]    step;
  logic [63:0]   pp;
  logic [1:0]    pp_off;
  logic [127:0]  acc;

  logic [31:0]   op_a;
  logic [31:0]   op_b;
  logic [1:0]    op_off;
  logic [127:0]  rsum;
  logic [127:0]  rq;
  logic [63:0]   rmag;

  always_comb begin
    case (step)
      3'd0:    begin op_a = ua[31:0];  op_b = ub[31:0];  op_off = 2'd0; end
      3'd1:    begin op_a = ua[31:0];  op_b = ub[63:32]; op_off = 2'd1; end
      3'd2:    begin op_a = ua[63:32]; op_b = ub[31:0];  op_off = 2'd1; end
      default: begin op_a = ua[63:32]; op_b = ub[63:32]; op_off = 2'd2; end
    endcase
    rsum = acc + (128'd1 << (shift - 6'd1));
    rq   = rsum >> shift;
    rmag = (|rq[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : rq[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == U_ROUND);
      case (state)
        U_IDLE: begin
          if (req.start) begin
            ua    <= req.a[63] ? (64'd0 - req.a) : req.a;
            ub    <= req.b[63] ? (64'd0 - req.b) : req.b;
            neg   <= req.a[63] ^ req.b[63];
            shift <= req.shift;
            acc   <= '0;
            step  <= 3'd0;
            state <= U_MUL;
          end
        end
        U_MUL: begin
          if (step < 3'd4) begin
            pp     <= op_a * op_b;
            pp_off <= op_off;
          end
          if (step != 3'd0) begin
            acc <= acc + ({64'd0, pp} << {pp_off, 5'd0});
          end
          if (step == 3'd4) begin
            state <= U_ROUND;
          end
          step <= step + 3'd1;
        end
        U_ROUND: begin
          rsp.result <= neg ? (64'sd0 - $signed(rmag)) : $signed(rmag);
          state      <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/coning_sculling_compensation.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    gyro_x/y/z, accel_x/y/z (32b signed)
// out       output     out_valid/out_stall  angle_inc_x/y/z, vel_inc_x/y/z (48b signed)
// cfg       input      cfg_write            cfg_index (0 count, 1 period), cfg_data
//
// One item at a time; in_stall is high from accept until the item is done.
// All products go through one shared 64x64 rounding multiplier built on a
// single 32x32 multiplier, one product in flight at a time. An item that does
// not close a group takes 12 products; a closing item takes 30 products plus
// a wait while a previous result is stalled.
// Synchronous reset clears the sequencer and the sums and resets count and period.
// The result sits in an output register; the next item is taken meanwhile.
module coning_sculling_compensation #(
  parameter int MAX_SUBSAMPLES = csc_pkg::MAX_SUBSAMPLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] gyro_x,
  input  wire logic signed [31:0] gyro_y,
  input  wire logic signed [31:0] gyro_z,
  input  wire logic signed [31:0] accel_x,
  input  wire logic signed [31:0] accel_y,
  input  wire logic signed [31:0] accel_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      angle_inc_x,
  output logic signed [47:0]      angle_inc_y,
  output logic signed [47:0]      angle_inc_z,
  output logic signed [47:0]      vel_inc_x,
  output logic signed [47:0]      vel_inc_y,
  output logic signed [47:0]      vel_inc_z
);
  import csc_pkg::*;

  localparam logic [2:0] NMAX = 3'(MAX_SUBSAMPLES);
  localparam logic        REG_COUNT  = 1'b0;
  localparam logic        REG_PERIOD = 1'b1;

  typedef enum logic [2:0] {S_IDLE, S_INC, S_WEIGHT, S_PREP, S_CROSS, S_FINISH} state_t;

  state_t             state;
  logic [2:0]         sample_count;
  logic [31:0]        sample_period;
  logic [2:0]         subsample_index;
  logic               close;
  logic [31:0]        coef;
  logic               issued;
  logic               issue;
  logic [2:0]         sub;
  logic [1:0]         set;

  logic signed [31:0] gyro_r [3];
  logic signed [31:0] accel_r [3];
  logic signed [63:0] dth [3];
  logic signed [63:0] dv [3];
  logic signed [63:0] cone [3];
  logic signed [63:0] scull [3];
  logic signed [63:0] asum [3];
  logic signed [63:0] vsum [3];
  logic signed [63:0] wsum [3];
  logic signed [63:0] vtot [3];
  logic signed [63:0] ang [3];
  logic signed [63:0] vel [3];

  csc_mul_req_t       req;
  csc_mul_rsp_t       rsp;

  logic [2:0]         n_eff;
  logic [1:0]         comp;
  csc_cross_t         xs;
  logic signed [63:0] op_a;
  logic signed [63:0] op_b;
  logic [5:0]         op_shift;
  logic signed [63:0] delta;
  logic               in_acc;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (v > OUT_MAX) t = OUT_MAX;
    if (v < OUT_MIN) t = OUT_MIN;
    return t[47:0];
  endfunction

  csc_mulshift u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = (state == S_INC || state == S_WEIGHT || state == S_CROSS) && !issued;

  // Out-of-range counts clamp to 2..MAX_SUBSAMPLES
  always_comb begin
    n_eff = sample_count;
    if (sample_count < 3'd2) n_eff = 3'd2;
    if (sample_count > NMAX) n_eff = NMAX;
  end

  // Operand select for the current product
  always_comb begin
    comp     = (sub < 3'd3) ? sub[1:0] : 2'(sub - 3'd3);
    xs       = csc_cross_sel(sub);
    op_a     = '0;
    op_b     = '0;
    op_shift = SH_CROSS;
    case (state)
      S_INC: begin
        op_b = {32'd0, sample_period};
        if (sub < 3'd3) begin
          op_a     = {{32{gyro_r[comp][31]}}, gyro_r[comp]};
          op_shift = SH_GYRO;
        end else begin
          op_a     = {{32{accel_r[comp][31]}}, accel_r[comp]};
          op_shift = SH_ACCEL;
        end
      end
      S_WEIGHT: begin
        op_a     = (sub < 3'd3) ? dth[comp] : dv[comp];
        op_b     = {32'd0, coef};
        op_shift = SH_COEF;
      end
      S_CROSS: begin
        case (set)
          2'd0:    begin op_a = cone[xs.a_idx];  op_b = dth[xs.b_idx]; end
          2'd1:    begin op_a = cone[xs.a_idx];  op_b = dv[xs.b_idx]; end
          2'd2:    begin op_a = scull[xs.a_idx]; op_b = dth[xs.b_idx]; end
          default: begin
            op_a     = wsum[xs.a_idx];
            op_b     = vtot[xs.b_idx];
            op_shift = SH_HALF;
          end
        endcase
      end
      default: ;
    endcase
    delta = xs.negate ? (64'sd0 - rsp.result) : rsp.result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sample_count    <= 3'd2;
      sample_period   <= 32'd42949673;
      subsample_index <= '0;
      issued          <= 1'b0;
      req.start       <= 1'b0;
      out_valid       <= 1'b0;
      sub             <= '0;
      set             <= '0;
      for (int i = 0; i < 3; i++) begin
        cone[i]  <= '0;
        scull[i] <= '0;
        asum[i]  <= '0;
        vsum[i]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COUNT:  sample_count  <= cfg_data[2:0];
          REG_PERIOD: sample_period <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !(state == S_FINISH && close)) out_valid <= 1'b0;

      // Issue one product, then wait for it
      req.start <= issue;
      if (issue) begin
        req.a     <= op_a;
        req.b     <= op_b;
        req.shift <= op_shift;
        issued    <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            gyro_r[0]  <= gyro_x;
            gyro_r[1]  <= gyro_y;
            gyro_r[2]  <= gyro_z;
            accel_r[0] <= accel_x;
            accel_r[1] <= accel_y;
            accel_r[2] <= accel_z;
            close      <= (subsample_index + 3'd1) >= n_eff;
            coef       <= csc_coef(n_eff, subsample_index);
            sub        <= '0;
            state      <= S_INC;
          end
        end
        S_INC: begin
          if (issued && rsp.done) begin
            issued <= 1'b0;
            if (sub < 3'd3) dth[comp] <= rsp.result;
            else            dv[comp]  <= rsp.result;
            if (sub == 3'd5) begin
              sub   <= '0;
              state <= close ? S_PREP : S_WEIGHT;
            end else begin
              sub <= sub + 3'd1;
            end
          end
        end
        S_WEIGHT: begin
          if (issued && rsp.done) begin
            issued <= 1'b0;
            if (sub < 3'd3) cone[comp]  <= cone[comp] + rsp.result;
            else            scull[comp] <= scull[comp] + rsp.result;
            if (sub == 3'd5) begin
              sub   <= '0;
              state <= S_FINISH;
            end else begin
              sub <= sub + 3'd1;
            end
          end
        end
        S_PREP: begin
          // W and V include the closing sample
          for (int i = 0; i < 3; i++) begin
            wsum[i] <= asum[i] + dth[i];
            vtot[i] <= vsum[i] + dv[i];
            ang[i]  <= asum[i] + dth[i];
            vel[i]  <= vsum[i] + dv[i];
          end
          sub   <= '0;
          set   <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          if (issued && rsp.done) begin
            issued <= 1'b0;
            if (set == 2'd0) ang[xs.comp] <= ang[xs.comp] + delta;
            else             vel[xs.comp] <= vel[xs.comp] + delta;
            if (sub == 3'd5) begin
              sub <= '0;
              if (set == 2'd3) state <= S_FINISH;
              else             set   <= set + 2'd1;
            end else begin
              sub <= sub + 3'd1;
            end
          end
        end
        S_FINISH: begin
          if (!close) begin
            for (int i = 0; i < 3; i++) begin
              asum[i] <= asum[i] + dth[i];
              vsum[i] <= vsum[i] + dv[i];
            end
            subsample_index <= subsample_index + 3'd1;
            state           <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            angle_inc_x <= sat48(ang[0]);
            angle_inc_y <= sat48(ang[1]);
            angle_inc_z <= sat48(ang[2]);
            vel_inc_x   <= sat48(vel[0]);
            vel_inc_y   <= sat48(vel[1]);
            vel_inc_z   <= sat48(vel[2]);
            out_valid   <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              cone[i]  <= '0;
              scull[i] <= '0;
              asum[i]  <= '0;
              vsum[i]  <= '0;
            end
            subsample_index <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A held group never reaches the largest group size
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    subsample_index < NMAX)
    else $error("subsample index out of range");

  // Multiplier answers only a product that was issued
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> issued)
    else $error("unexpected multiplier result");

  // A new result comes only from the finishing step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish");

  // An accepted item starts with the increment products
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_INC)
    else $error("accepted item not started");

endmodule

`default_nettype wire

>>> tb/coning_sculling_compensation_tb.sv
`timescale 1ns / 100ps

module coning_sculling_compensation_tb;

  import csc_pkg::*;

  // register indexes on the cfg port
  localparam logic CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic CFG_SAMPLE_PERIOD = 1'b1;

  localparam logic [31:0] PERIOD_AT_RESET = 32'd42949673;
  // quiet-down time, well over what a closing item takes
  localparam int SETTLE_CYCLES = 400;
  localparam int SEGMENTS      = 16;

  typedef struct {
    logic signed [47:0] ang[3];
    logic signed [47:0] vel[3];
  } imu_delta_t;

  typedef struct {
    logic signed [31:0] gyro[3];
    logic signed [31:0] accel[3];
    bit                 typed;   // expected result typed in below
    logic signed [47:0] exp_val; // same value on all six fields
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [31:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] angle_inc_x, angle_inc_y, angle_inc_z;
  logic signed [47:0] vel_inc_x, vel_inc_y, vel_inc_z;

  coning_sculling_compensation u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_inc_x(angle_inc_x), .angle_inc_y(angle_inc_y), .angle_inc_z(angle_inc_z),
    .vel_inc_x(vel_inc_x), .vel_inc_y(vel_inc_y), .vel_inc_z(vel_inc_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: shadow registers and accumulators of the block
  // ---------------------------------------------------------------------
  logic [2:0]         count_reg;
  logic [31:0]        period_reg;
  logic signed [63:0] cone_acc[3], scull_acc[3], dth_total[3], dv_total[3];
  int unsigned        held_samples;

  imu_delta_t pending_deltas[$];
  int errors = 0;
  int items_sent = 0;
  int deltas_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // coefficient rows by group size (row n-2), Q2.30 = round(num/den * 2^30)
  int unsigned coef_num[5][5] = '{
    '{2, 0, 0, 0, 0},
    '{9, 27, 0, 0, 0},
    '{54, 92, 214, 0, 0},
    '{250, 525, 650, 1375, 0},
    '{2315, 4558, 7296, 7834, 15797}};
  int unsigned coef_den[5] = '{3, 20, 105, 504, 4620};

  function automatic logic signed [63:0] coef_q30(int unsigned row, int unsigned col);
    logic [63:0] q;
    q = ((64'(coef_num[row][col]) << 31) / 64'(coef_den[row]) + 64'd1) >> 1;
    return q;
  endfunction

  // round(a*b / 2^sh) half away from zero, magnitude capped at int64 max
  function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    logic         neg;
    neg = a[63] ^ b[63];
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -p[63:0] : p[63:0];
  endfunction

  function automatic void cross_accum(input logic signed [63:0] a[3],
                                      input logic signed [63:0] b[3], input int sh,
                                      inout logic signed [63:0] acc[3]);
    acc[0] += round_mul(a[1], b[2], sh) - round_mul(a[2], b[1], sh);
    acc[1] += round_mul(a[2], b[0], sh) - round_mul(a[0], b[2], sh);
    acc[2] += round_mul(a[0], b[1], sh) - round_mul(a[1], b[0], sh);
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[47:0];
  endfunction

  function automatic void clear_group();
    for (int i = 0; i < 3; i++) begin
      cone_acc[i] = '0;
      scull_acc[i] = '0;
      dth_total[i] = '0;
      dv_total[i] = '0;
    end
    held_samples = 0;
  endfunction

  // Steps the shadow model by one sample; returns 1 when the group closes
  function automatic bit integrate_sample(input logic signed [31:0] g[3],
                                          input logic signed [31:0] f[3],
                                          output imu_delta_t d);
    logic signed [63:0] dth[3], dv[3], w[3], v[3], ang[3], vel[3], c;
    int unsigned n;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > MAX_SUBSAMPLES_DEF) n = MAX_SUBSAMPLES_DEF;
    for (int i = 0; i < 3; i++) begin
      dth[i] = round_mul(64'(g[i]), {32'd0, period_reg}, 24);
      dv[i] = round_mul(64'(f[i]), {32'd0, period_reg}, 28);
    end
    if (held_samples + 1 < n) begin
      // weights are fixed by the row in force when the sample arrives
      c = coef_q30(n - 2, held_samples);
      for (int i = 0; i < 3; i++) begin
        cone_acc[i] += round_mul(dth[i], c, 30);
        scull_acc[i] += round_mul(dv[i], c, 30);
        dth_total[i] += dth[i];
        dv_total[i] += dv[i];
      end
      held_samples++;
      return 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      w[i] = dth_total[i] + dth[i];
      v[i] = dv_total[i] + dv[i];
      ang[i] = w[i];
      vel[i] = v[i];
    end
    cross_accum(cone_acc, dth, 32, ang);   // coning
    cross_accum(cone_acc, dv, 32, vel);    // sculling, gyro-weighted part
    cross_accum(scull_acc, dth, 32, vel);  // sculling, accel-weighted part
    cross_accum(w, v, 33, vel);            // rotation term, one half
    for (int i = 0; i < 3; i++) begin
      d.ang[i] = clamp48(ang[i]);
      d.vel[i] = clamp48(vel[i]);
    end
    clear_group();
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------
  // leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_SAMPLE_COUNT) count_reg = val[2:0];
    else period_reg = val;
  endtask

  // block fully idle: no result owed and nothing in flight
  task automatic wait_quiet();
    while (pending_deltas.size() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called just after a rising edge; returns just after the accepting edge
  task automatic send_sample(input logic signed [31:0] g[3], input logic signed [31:0] f[3],
                             input bit typed, input logic signed [47:0] exp_val);
    imu_delta_t d;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    gyro_x <= g[0]; gyro_y <= g[1]; gyro_z <= g[2];
    accel_x <= f[0]; accel_y <= f[1]; accel_z <= f[2];
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (integrate_sample(g, f, d)) begin
      if (typed) begin
        for (int i = 0; i < 3; i++) begin
          d.ang[i] = exp_val;
          d.vel[i] = exp_val;
        end
      end
      pending_deltas.push_back(d);
    end
  endtask

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 28);
    endcase
  endfunction

  function automatic logic [31:0] rand_period();
    case ($urandom_range(5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd1;
      2: return $urandom;
      default: return $urandom_range(1000, 100_000_000);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Checking side: out_stall is redrawn every cycle, results sampled at edges
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_deltas.size() == 0) begin
        $display("%0t unexpected result", $realtime);
        errors++;
      end else begin
        imu_delta_t e;
        e = pending_deltas.pop_front();
        deltas_checked++;
        if (angle_inc_x !== e.ang[0]) report("angle_inc_x", angle_inc_x, e.ang[0]);
        if (angle_inc_y !== e.ang[1]) report("angle_inc_y", angle_inc_y, e.ang[1]);
        if (angle_inc_z !== e.ang[2]) report("angle_inc_z", angle_inc_z, e.ang[2]);
        if (vel_inc_x !== e.vel[0]) report("vel_inc_x", vel_inc_x, e.vel[0]);
        if (vel_inc_y !== e.vel[1]) report("vel_inc_y", vel_inc_y, e.vel[1]);
        if (vel_inc_z !== e.vel[2]) report("vel_inc_z", vel_inc_z, e.vel[2]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed rows, run at reset settings (pairs of samples, count 2)
  // ---------------------------------------------------------------------
  localparam logic signed [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] NMAX = 32'h8000_0000;

  stim_row_t directed[] = '{
    // zero samples give a zero group
    '{'{0, 0, 0}, '{0, 0, 0}, 1'b0, 48'sd0},
    '{'{0, 0, 0}, '{0, 0, 0}, 1'b1, 48'sd0},
    // full-scale positive, then full-scale negative, on every axis
    '{'{PMAX, PMAX, PMAX}, '{PMAX, PMAX, PMAX}, 1'b0, 48'sd0},
    '{'{PMAX, PMAX, PMAX}, '{PMAX, PMAX, PMAX}, 1'b0, 48'sd0},
    '{'{NMAX, NMAX, NMAX}, '{NMAX, NMAX, NMAX}, 1'b0, 48'sd0},
    '{'{NMAX, NMAX, NMAX}, '{NMAX, NMAX, NMAX}, 1'b0, 48'sd0},
    // opposing extremes drive the cross products hard
    '{'{PMAX, NMAX, PMAX}, '{NMAX, PMAX, NMAX}, 1'b0, 48'sd0},
    '{'{NMAX, PMAX, 0}, '{PMAX, 0, NMAX}, 1'b0, 48'sd0},
    // single lsb values, rounding at the half point
    '{'{1, -1, 32'sd2}, '{-1, 1, 32'sd8}, 1'b0, 48'sd0},
    '{'{-1, 1, 32'sd3}, '{32'sd16, -1, 1}, 1'b0, 48'sd0},
    // bit patterns
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0}, 1'b0, 48'sd0},
    '{'{32'h0100_0000, 32'h0200_0000, -32'sh0100_0000},
      '{32'h0010_0000, -32'sh0020_0000, 32'h0040_0000}, 1'b0, 48'sd0}
  };

  // settings per random segment; count includes out-of-range codes 0, 1 and 7
  logic [2:0]  seg_count[8]  = '{3'd6, 3'd3, 3'd0, 3'd7, 3'd5, 3'd1, 3'd4, 3'd2};
  logic [31:0] seg_period[8] = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd4000000,
                                 32'd42949673, 32'hFFFF_FFFF, 32'd0, 32'd123456};

  initial begin
    logic signed [31:0] g[3], f[3];
    count_reg = 3'd2;
    period_reg = PERIOD_AT_RESET;
    clear_group();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r])
      send_sample(directed[r].gyro, directed[r].accel, directed[r].typed, directed[r].exp_val);
    in_valid <= 1'b0;

    // Random segments. Groups are left half full across segments, so register
    // writes land mid-group, including a lowered count closing the group early.
    for (int s = 0; s < SEGMENTS; s++) begin
      wait_quiet();
      write_reg(CFG_SAMPLE_COUNT, s < 8 ? {29'd0, seg_count[s]} : $urandom_range(0, 7));
      write_reg(CFG_SAMPLE_PERIOD, s < 8 ? seg_period[s] : rand_period());
      cfg_write <= 1'b0;
      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat ($urandom_range(70, 130)) begin
        for (int i = 0; i < 3; i++) begin
          g[i] = rand_field();
          f[i] = rand_field();
        end
        send_sample(g, f, 1'b0, 48'sd0);
      end
      in_valid <= 1'b0;
    end

    wait_quiet();
    $display("tb: %0d samples sent over %0d register settings, %0d compensated deltas checked",
             items_sent, 2 * SEGMENTS, deltas_checked);
    $display("tb: group sizes 0..7 written, periods 0, 1 and full scale, four idle mixes");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/csc_pkg.sv
rtl/core/csc_mulshift.sv
rtl/core/coning_sculling_compensation.sv
tb/coning_sculling_compensation_tb.sv
